/* rtl/mhsm_pkg.sv */
// Types and codes shared by the multi-handle stack manager.
`default_nettype none
package mhsm_pkg;

    localparam logic [2:0] CMD_CREATE  = 3'd0;
    localparam logic [2:0] CMD_PUSH    = 3'd1;
    localparam logic [2:0] CMD_POP     = 3'd2;
    localparam logic [2:0] CMD_DESTROY = 3'd3;
    localparam logic [2:0] CMD_COUNT   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSTACK  = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOHANDLE = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  handle;
        logic [31:0] data;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  new_handle;
        logic [31:0] data_out;
        logic [4:0]  elem_count;
    } out_t;

endpackage
`default_nettype wire

/* rtl/mhsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mhsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/multi_handle_stack_manager_core.sv */
// Multi-handle LIFO stack manager: handle table, fill levels and element RAM control.
// Results: a result is registered on the clock edge that accepts its transaction; a
// successful pop's word passes through the element RAM read register, then the output
// register. Throughput: one transaction per cycle while the receiver takes results,
// but a successful pop holds off the input until its word reaches the output register.
// Reset: live bits and fill levels clear synchronously; the element RAM is not cleared.
`default_nettype none
module multi_handle_stack_manager_core #(
    parameter int NUM_STACKS  = 8,
    parameter int STACK_DEPTH = 16,
    parameter int ELEM_WIDTH  = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire mhsm_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mhsm_pkg::out_t      m_data
);

    localparam int SLOT_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FILL_W = $clog2(STACK_DEPTH + 1);
    localparam int MEM_D  = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W = $clog2(MEM_D);
    localparam int WORD_W = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;
    localparam logic [7:0]        HANDLE_MAX = 8'(NUM_STACKS);
    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(STACK_DEPTH);

    logic [NUM_STACKS-1:0] live_reg, live_next;
    logic [FILL_W-1:0]     fill_reg  [NUM_STACKS];
    logic [FILL_W-1:0]     fill_next [NUM_STACKS];
    logic                  out_valid_reg;
    logic                  pend_reg;
    mhsm_pkg::out_t        out_reg;

    logic                  accept;
    logic                  h_ok;
    logic [SLOT_W-1:0]     slot;
    logic                  sel_live;
    logic [FILL_W-1:0]     sel_fill;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic                  pop_go;
    logic                  ram_we;
    logic                  ram_re;
    logic [FILL_W-1:0]     ram_idx;
    logic [ADDR_W-1:0]     ram_addr;
    logic [WORD_W-1:0]     ram_rdata;
    mhsm_pkg::out_t        res;
    mhsm_pkg::out_t        pop_res;

    assign s_ready = !pend_reg && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign h_ok     = (s_data.handle != 8'd0) && (s_data.handle <= HANDLE_MAX);
    assign slot     = SLOT_W'(s_data.handle - 8'd1);
    assign sel_live = h_ok && live_reg[slot];
    assign sel_fill = fill_reg[slot];
    assign ram_addr = ADDR_W'(32'(slot) * STACK_DEPTH + 32'(ram_idx));

    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_STACKS - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        live_next = live_reg;
        fill_next = fill_reg;
        res       = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_idx   = sel_fill;
        pop_go    = 1'b0;
        unique case (s_data.cmd)
            mhsm_pkg::CMD_CREATE: begin
                if (free_found) begin
                    live_next[free_slot] = 1'b1;
                    fill_next[free_slot] = '0;
                    res.new_handle       = 4'(32'(free_slot) + 32'd1);
                end else begin
                    res.status = mhsm_pkg::ST_NOHANDLE;
                end
            end
            mhsm_pkg::CMD_PUSH: begin
                if (!sel_live) begin
                    res.status = mhsm_pkg::ST_NOSTACK;
                end else if (sel_fill >= FILL_MAX) begin
                    res.status = mhsm_pkg::ST_FULL;
                end else begin
                    ram_we          = accept;
                    fill_next[slot] = sel_fill + FILL_W'(1);
                end
            end
            mhsm_pkg::CMD_POP: begin
                if (!sel_live) begin
                    res.status = mhsm_pkg::ST_NOSTACK;
                end else if (sel_fill == '0) begin
                    res.status = mhsm_pkg::ST_EMPTY;
                end else begin
                    ram_idx         = sel_fill - FILL_W'(1);
                    ram_re          = accept;
                    pop_go          = 1'b1;
                    fill_next[slot] = sel_fill - FILL_W'(1);
                end
            end
            mhsm_pkg::CMD_DESTROY: begin
                if (|live_reg) begin
                    if (!sel_live) begin
                        res.status = mhsm_pkg::ST_NOSTACK;
                    end else begin
                        live_next[slot] = 1'b0;
                        fill_next[slot] = '0;
                    end
                end
            end
            mhsm_pkg::CMD_COUNT: begin
                if (!sel_live) begin
                    res.status = mhsm_pkg::ST_NOSTACK;
                end else begin
                    res.elem_count = 5'(sel_fill);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        pop_res          = '0;
        pop_res.status   = mhsm_pkg::ST_OK;
        pop_res.data_out = 32'(ram_rdata);
    end

    mhsm_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MEM_D)
    ) u_elem_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(WORD_W'(s_data.data)),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                live_reg <= live_next;
                fill_reg <= fill_next;
            end
            if (accept && !pop_go) begin
                out_valid_reg <= 1'b1;
            end else if (accept) begin
                pend_reg      <= 1'b1;
                out_valid_reg <= 1'b0;
            end else if (pend_reg && (!out_valid_reg || m_ready)) begin
                pend_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !pop_go) begin
            out_reg <= res;
        end else if (pend_reg && (!out_valid_reg || m_ready)) begin
            out_reg <= pop_res;
        end
    end

endmodule
`default_nettype wire

/* verif/mhsm_stack_checker.sv */
// Scoreboard for the stack manager: predicts every result and compares it on the result channel.
module mhsm_stack_checker #(
    parameter int NUM_STACKS  = 8,
    parameter int STACK_DEPTH = 16,
    parameter int ELEM_WIDTH  = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  mhsm_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  mhsm_pkg::out_t m_data,
    output int             mismatches,
    output int             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mhsm_pkg::*;

    localparam logic [31:0] WORD_MASK =
        (ELEM_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'h1 << ELEM_WIDTH) - 32'h1);

    logic        stack_live [NUM_STACKS];
    int          stack_level [NUM_STACKS];
    logic [31:0] stack_words [NUM_STACKS*STACK_DEPTH];
    out_t        pending_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        for (int i = 0; i < NUM_STACKS; i++) begin
            stack_live[i]  = 1'b0;
            stack_level[i] = 0;
        end
        for (int i = 0; i < NUM_STACKS*STACK_DEPTH; i++) begin
            stack_words[i] = '0;
        end
    end

    function automatic out_t apply_command(in_t c);
        out_t r;
        int   slot;
        int   i;
        logic any_live;
        r        = '0;
        r.status = ST_OK;
        slot     = -1;
        any_live = 1'b0;
        if (c.handle >= 1 && c.handle <= NUM_STACKS) begin
            if (stack_live[c.handle - 1]) begin
                slot = int'(c.handle) - 1;
            end
        end
        for (i = 0; i < NUM_STACKS; i++) begin
            any_live = any_live | stack_live[i];
        end
        case (c.cmd)
            CMD_CREATE: begin
                r.status = ST_NOHANDLE;
                for (i = 0; i < NUM_STACKS; i++) begin
                    if (!stack_live[i] && r.status == ST_NOHANDLE) begin
                        stack_live[i]  = 1'b1;
                        stack_level[i] = 0;
                        r.new_handle   = 4'(i + 1);
                        r.status       = ST_OK;
                    end
                end
            end
            CMD_PUSH: begin
                if (slot < 0) begin
                    r.status = ST_NOSTACK;
                end else if (stack_level[slot] >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_words[slot*STACK_DEPTH + stack_level[slot]] = c.data & WORD_MASK;
                    stack_level[slot]++;
                end
            end
            CMD_POP: begin
                if (slot < 0) begin
                    r.status = ST_NOSTACK;
                end else if (stack_level[slot] == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    stack_level[slot]--;
                    r.data_out = stack_words[slot*STACK_DEPTH + stack_level[slot]];
                end
            end
            CMD_DESTROY: begin
                // with nothing live, destroy succeeds regardless of handle
                if (any_live) begin
                    if (slot < 0) begin
                        r.status = ST_NOSTACK;
                    end else begin
                        stack_live[slot]  = 1'b0;
                        stack_level[slot] = 0;
                    end
                end
            end
            CMD_COUNT: begin
                if (slot < 0) begin
                    r.status = ST_NOSTACK;
                end else begin
                    r.elem_count = 5'(stack_level[slot]);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("new_handle", 32'(want.new_handle), 32'(m_data.new_handle));
                    check_field("data_out", want.data_out, m_data.data_out);
                    check_field("elem_count", 32'(want.elem_count), 32'(m_data.elem_count));
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(apply_command(s_data));
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

/* verif/tb.sv */
// Testbench top for the stack manager: clock, reset, traffic generation and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhsm_pkg::*;

    localparam int NUM_HANDLES    = 8;
    localparam int RANDOM_ITEMS   = 1525;
    localparam int HOLD_AFTER     = 600;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } traffic_mix_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int           mismatches;
    int           outstanding;
    int           items_sent;
    int           idle_cycles;
    int           recv_stall;
    int           n;
    bit           quiet;
    bit           hold_done;
    traffic_mix_t mix;
    logic [7:0]   focus;

    multi_handle_stack_manager_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    mhsm_stack_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    function automatic in_t cmd_item(logic [2:0] c, logic [7:0] h, logic [31:0] d);
        in_t t;
        t.cmd    = c;
        t.handle = h;
        t.data   = d;
        return t;
    endfunction

    function automatic in_t random_command(traffic_mix_t m, logic [7:0] f);
        in_t t;
        int  roll;
        int  push_cut;
        t.data = $urandom;
        case ($urandom_range(0, 7))
            0: t.data = '0;
            1: t.data = '1;
            default: begin
            end
        endcase
        t.handle = ($urandom_range(0, 9) < 7) ? f : 8'($urandom_range(1, NUM_HANDLES));
        push_cut = (m == MIX_FILL) ? 85 : (m == MIX_DRAIN) ? 50 : 67;
        roll     = $urandom_range(0, 99);
        if (roll < 10) begin
            t.cmd    = 3'($urandom);
            t.handle = 8'($urandom);
        end else if (roll < 18) begin
            t.cmd = CMD_CREATE;
        end else if (roll < 25) begin
            t.cmd = CMD_DESTROY;
        end else if (roll < 35) begin
            t.cmd = CMD_COUNT;
        end else if (roll < push_cut) begin
            t.cmd = CMD_PUSH;
        end else begin
            t.cmd = CMD_POP;
        end
        return t;
    endfunction

    task automatic send_item(input in_t item);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end
            recv_stall = quiet ? 0 : $urandom_range(0, 7);
            if (recv_stall > 0) begin
                m_ready <= 1'b0;
                repeat (recv_stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        idle_cycles = 0;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[multi_handle_stack_manager_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        items_sent = 0;
        quiet      = 1'b0;
        mix        = MIX_EVEN;
        focus      = 8'd1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(cmd_item(CMD_DESTROY, 8'd1, 32'h0));
        send_item(cmd_item(CMD_POP, 8'd0, 32'h0));
        send_item(cmd_item(CMD_COUNT, 8'd9, 32'h0));
        send_item(cmd_item(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF));
        send_item(cmd_item(CMD_UNUSED_LO, 8'd1, 32'hFFFF_FFFF));
        send_item(cmd_item(CMD_UNUSED_HI, 8'hFF, 32'hFFFF_FFFF));
        send_item(cmd_item(CMD_CREATE, 8'hFF, 32'hFFFF_FFFF));
        send_item(cmd_item(CMD_COUNT, 8'd2, 32'h0));
        send_item(cmd_item(CMD_POP, 8'd1, 32'h0));
        send_item(cmd_item(CMD_PUSH, 8'd1, 32'h0));
        send_item(cmd_item(CMD_PUSH, 8'd1, 32'hFFFF_FFFF));
        send_item(cmd_item(CMD_COUNT, 8'd1, 32'h0));
        send_item(cmd_item(CMD_POP, 8'd1, 32'h0));
        send_item(cmd_item(CMD_POP, 8'd1, 32'h0));
        send_item(cmd_item(CMD_DESTROY, 8'd1, 32'h0));
        send_item(cmd_item(CMD_DESTROY, 8'd1, 32'h0));
        // take every handle, then one create too many
        repeat (NUM_HANDLES + 1) send_item(cmd_item(CMD_CREATE, 8'd0, 32'h0));

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                mix   = traffic_mix_t'($urandom_range(0, 2));
                quiet = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0) begin
                focus = 8'($urandom_range(1, NUM_HANDLES));
            end
            send_item(random_command(mix, focus));
        end
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[multi_handle_stack_manager_core] OK");
        end else begin
            $display("[multi_handle_stack_manager_core] ERROR");
        end
        $finish;
    end

endmodule
